@@ hw/rtl/ppsjm_pkg.sv @@
// ppsjm_pkg: shared widths, codes, command/status structs and helpers
// for the pps interval jitter monitor; no dependencies
`default_nettype none

package ppsjm_pkg;

  // window storage
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned NW    = AW;

  // field widths
  localparam int unsigned TW    = 63;
  localparam int unsigned IVW   = 40;
  localparam int unsigned RATEW = 46;
  localparam int unsigned JITW  = 39;
  localparam int unsigned WSW   = 7;
  localparam int unsigned LIMW  = 32;
  localparam int unsigned BWW   = 16;

  // arithmetic widths
  localparam int unsigned S1W   = IVW + NW + 1;
  localparam int unsigned EW    = S1W + 1;
  localparam int unsigned MW    = 48;
  localparam int unsigned HALF  = MW / 2;
  localparam int unsigned ACCW  = 101;
  localparam int unsigned REMW  = 63;
  localparam int unsigned SQW   = (ACCW + 1) / 2;
  localparam int unsigned RADW  = 2 * SQW;
  localparam int unsigned SRW   = SQW + 2;
  localparam int unsigned PICOW = 40;
  localparam int unsigned NUMW  = NW + PICOW;
  localparam int unsigned STW   = 7;

  localparam logic [PICOW-1:0]        PICO_PER_SEC = 40'd1000000000000;
  localparam logic [JITW-1:0]         JIT_MAX      = '1;
  localparam logic signed [LIMW-1:0]  STALE_RESET  = 32'sd1500000000;
  localparam logic [WSW-1:0]          WS_RESET     = 7'd64;

  // configuration register indexes
  localparam int unsigned CFG_IDXW = 2;
  localparam logic [CFG_IDXW-1:0] CFG_STALE_LIMIT = 2'd0;
  localparam logic [CFG_IDXW-1:0] CFG_WINDOW_SIZE = 2'd1;

  // request operations
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // partial product phases of the squaring step
  localparam logic [1:0] MPH_LO  = 2'd0;
  localparam logic [1:0] MPH_MID = 2'd1;
  localparam logic [1:0] MPH_HI  = 2'd2;

  typedef struct packed {
    logic          observe;
    logic          query;
    logic          rd_en;
    logic [AW-1:0] rd_idx;
    logic          first;
    logic          p1_acc;
    logic          p2_err;
    logic          mul_en;
    logic [1:0]    mul_ph;
    logic          div_start;
    logic          div_var;
    logic          div_step;
    logic          rate_take;
    logic          sqrt_start;
    logic          sqrt_step;
    logic          load_out;
  } ppsjm_cmd_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          out_busy;
  } ppsjm_sts_t;

  function automatic logic signed [IVW-1:0] sat_iv(input logic signed [63:0] d);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd549755813887;
    lo = -64'sd549755813888;
    if (d > hi) begin
      sat_iv = hi[IVW-1:0];
    end else if (d < lo) begin
      sat_iv = lo[IVW-1:0];
    end else begin
      sat_iv = d[IVW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ppsjm_ctrl.sv @@
// ppsjm_ctrl: sequencer for observe and query requests
// depends on ppsjm_pkg
`default_nettype none

module ppsjm_ctrl import ppsjm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       operation_i,
  input  wire ppsjm_sts_t sts_i,
  output ppsjm_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_P1_RD    = 4'd1;
  localparam logic [3:0] S_P1_ACC   = 4'd2;
  localparam logic [3:0] S_P2_RD    = 4'd3;
  localparam logic [3:0] S_P2_ERR   = 4'd4;
  localparam logic [3:0] S_M_LO     = 4'd5;
  localparam logic [3:0] S_M_MID    = 4'd6;
  localparam logic [3:0] S_M_HI     = 4'd7;
  localparam logic [3:0] S_DIV_RATE = 4'd8;
  localparam logic [3:0] S_RATE_FIN = 4'd9;
  localparam logic [3:0] S_DIV_VAR  = 4'd10;
  localparam logic [3:0] S_VAR_FIN  = 4'd11;
  localparam logic [3:0] S_SQRT     = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]     state_q, state_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [STW-1:0] cnt_q, cnt_d;
  logic           last;

  assign last = (CW'(idx_q) == (sts_i.count - CW'(1)));

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_idx  = idx_q;
    cmd_o.first   = (idx_q == '0);
    cmd_o.mul_ph  = MPH_LO;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_QUERY) begin
            cmd_o.query = 1'b1;
            idx_d       = '0;
            state_d     = (sts_i.count >= CW'(2)) ? S_P1_RD : S_DONE;
          end else begin
            cmd_o.observe = 1'b1;
          end
        end
      end
      S_P1_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_P1_ACC;
      end
      S_P1_ACC: begin
        cmd_o.p1_acc = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = S_P2_RD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_P1_RD;
        end
      end
      S_P2_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_P2_ERR;
      end
      S_P2_ERR: begin
        cmd_o.p2_err = 1'b1;
        // oldest stamp only seeds the previous-stamp register
        if (idx_q == '0) begin
          idx_d   = AW'(1);
          state_d = S_P2_RD;
        end else begin
          state_d = S_M_LO;
        end
      end
      S_M_LO: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = MPH_LO;
        state_d      = S_M_MID;
      end
      S_M_MID: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = MPH_MID;
        state_d      = S_M_HI;
      end
      S_M_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = MPH_HI;
        if (last) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV_RATE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_P2_RD;
        end
      end
      S_DIV_RATE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + STW'(1);
        if (cnt_q == STW'(ACCW - 1)) begin
          state_d = S_RATE_FIN;
        end
      end
      S_RATE_FIN: begin
        cmd_o.rate_take = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_var   = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV_VAR;
      end
      S_DIV_VAR: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + STW'(1);
        if (cnt_q == STW'(ACCW - 1)) begin
          state_d = S_VAR_FIN;
        end
      end
      S_VAR_FIN: begin
        cmd_o.sqrt_start = 1'b1;
        cnt_d            = '0;
        state_d          = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + STW'(1);
        if (cnt_q == STW'(SQW - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ppsjm_dp.sv @@
// ppsjm_dp: stamp window memory, pulse state, interval walk, shared divider,
// square root unit and result register; depends on ppsjm_pkg
`default_nettype none

module ppsjm_dp import ppsjm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ppsjm_cmd_t            cmd_i,
  output ppsjm_sts_t                 sts_o,
  input  wire logic                  cfg_fire_i,
  input  wire logic [CFG_IDXW-1:0]   cfg_index_i,
  input  wire logic [LIMW-1:0]       cfg_data_i,
  input  wire logic [TW-1:0]         event_stamp_ns_i,
  input  wire logic [TW-1:0]         receipt_time_ns_i,
  input  wire logic [TW-1:0]         now_ns_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic                       went_backwards_o,
  output logic [BWW-1:0]             regressions_o,
  output logic [CW-1:0]              samples_held_o,
  output logic                       is_stale_o,
  output logic [RATEW-1:0]           rate_mhz_o,
  output logic signed [IVW-1:0]      last_interval_ns_o,
  output logic [JITW-1:0]            interval_jitter_ns_o
);

  // pulse state and configuration
  logic [AW-1:0]          head_q;
  logic [CW-1:0]          count_q, count_d, cnt_inc, win;
  logic [TW-1:0]          receipt_q, prev_stamp_q;
  logic                   seen_q, bw_q;
  logic [BWW-1:0]         bwcnt_q;
  logic signed [LIMW-1:0] limit_q;
  logic [WSW-1:0]         ws_q;
  logic                   backward;

  // window memory
  logic [TW-1:0]          ring [DEPTH];
  logic [TW-1:0]          rd_q;
  logic [AW-1:0]          rd_addr;

  // walk registers
  logic [TW-1:0]          prev_w_q, oldest_q;
  logic signed [63:0]     span_q, diff, span_d;
  logic signed [IVW-1:0]  d, last_q;
  logic signed [S1W-1:0]  s1_q;
  logic [NW-1:0]          n_q;
  logic [2*NW-1:0]        n2_q;
  logic [3*NW-1:0]        n3_q;
  logic                   k2_q, stale_q;
  logic signed [S1W-1:0]  nd;
  logic signed [EW-1:0]   e;
  logic [MW-1:0]          m_q;
  logic [ACCW-1:0]        total_q, addend;
  logic [HALF-1:0]        mul_a, mul_b;
  logic [2*HALF-1:0]      prod;

  // divider and square root
  logic [ACCW-1:0]        dq_q;
  logic [REMW-1:0]        rem_q, divisor_q;
  logic [REMW:0]          dt;
  logic                   dge;
  logic [NUMW-1:0]        num;
  logic [RATEW-1:0]       rate_q;
  logic [RADW-1:0]        rad_q;
  logic [SQW-1:0]         root_q;
  logic [SRW-1:0]         srem_q;
  logic [SRW+1:0]         st, trial;
  logic                   sge;
  logic [JITW-1:0]        jitter;
  logic signed [63:0]     age, lim_ext;
  logic                   stale_now;
  logic                   out_valid_q;

  assign sts_o.count    = count_q;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;

  // window trim on observe
  always_comb begin
    cnt_inc = (count_q < CW'(DEPTH)) ? count_q + CW'(1) : count_q;
    if ({{CW{1'b0}}, ws_q} > (CW + WSW)'(DEPTH)) begin
      win = CW'(DEPTH);
    end else begin
      win = CW'(ws_q);
    end
    count_d = (cnt_inc > win) ? win : cnt_inc;
  end

  assign backward = seen_q && (event_stamp_ns_i < prev_stamp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      receipt_q    <= '0;
      prev_stamp_q <= '0;
      seen_q       <= 1'b0;
      bw_q         <= 1'b0;
      bwcnt_q      <= '0;
      limit_q      <= STALE_RESET;
      ws_q         <= WS_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_fire_i) begin
        if (cfg_index_i == CFG_STALE_LIMIT) begin
          limit_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_WINDOW_SIZE) begin
          ws_q <= cfg_data_i[WSW-1:0];
        end
      end
      if (cmd_i.observe) begin
        if (backward) begin
          bw_q <= 1'b1;
          if (bwcnt_q != '1) begin
            bwcnt_q <= bwcnt_q + BWW'(1);
          end
        end
        seen_q       <= 1'b1;
        prev_stamp_q <= event_stamp_ns_i;
        receipt_q    <= receipt_time_ns_i;
        head_q       <= head_q + AW'(1);
        count_q      <= count_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // oldest held stamp sits count entries behind the head
  assign rd_addr = head_q - count_q[AW-1:0] + cmd_i.rd_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.observe) begin
      ring[head_q] <= event_stamp_ns_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= ring[rd_addr];
    end
  end

  // staleness is judged against now at request time
  always_comb begin
    age       = $signed({1'b0, now_ns_i}) - $signed({1'b0, receipt_q});
    lim_ext   = 64'(limit_q);
    stale_now = (count_q != '0) && ((limit_q < 0) || (age > lim_ext));
  end

  always_comb begin
    diff   = $signed({1'b0, rd_q}) - $signed({1'b0, prev_w_q});
    d      = sat_iv(diff);
    span_d = $signed({1'b0, rd_q}) - $signed({1'b0, oldest_q});
    nd     = $signed({1'b0, n_q}) * d;
    e      = EW'(nd) - EW'(s1_q);
  end

  // one 24x24 partial product per cycle into the square sum
  always_comb begin
    mul_a  = m_q[HALF-1:0];
    mul_b  = m_q[HALF-1:0];
    addend = '0;
    case (cmd_i.mul_ph)
      MPH_LO: begin
        mul_a = m_q[HALF-1:0];
        mul_b = m_q[HALF-1:0];
      end
      MPH_MID: begin
        mul_a = m_q[MW-1:HALF];
        mul_b = m_q[HALF-1:0];
      end
      MPH_HI: begin
        mul_a = m_q[MW-1:HALF];
        mul_b = m_q[MW-1:HALF];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    case (cmd_i.mul_ph)
      MPH_MID: addend = ACCW'(prod) << (HALF + 1);
      MPH_HI:  addend = ACCW'(prod) << (2 * HALF);
      default: addend = ACCW'(prod);
    endcase
  end

  always_ff @(posedge clk_i) begin
    n2_q <= n_q * n_q;
    n3_q <= n2_q * n_q;
    if (cmd_i.query) begin
      s1_q    <= '0;
      total_q <= '0;
      n_q     <= NW'(count_q - CW'(1));
      k2_q    <= (count_q >= CW'(2));
      stale_q <= stale_now;
    end
    if (cmd_i.p1_acc) begin
      prev_w_q <= rd_q;
      if (cmd_i.first) begin
        oldest_q <= rd_q;
      end else begin
        s1_q   <= s1_q + S1W'(d);
        last_q <= d;
        span_q <= span_d;
      end
    end
    if (cmd_i.p2_err) begin
      prev_w_q <= rd_q;
      m_q      <= e[EW-1] ? MW'(-e) : MW'(e);
    end
    if (cmd_i.mul_en) begin
      total_q <= total_q + addend;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign num = n_q * PICO_PER_SEC;
  assign dt  = {rem_q, dq_q[ACCW-1]};
  assign dge = (dt >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_var) begin
        dq_q      <= total_q;
        divisor_q <= REMW'(n3_q);
      end else begin
        dq_q      <= ACCW'(num);
        divisor_q <= span_q[REMW-1:0];
      end
    end else if (cmd_i.div_step) begin
      rem_q <= dge ? REMW'(dt - {1'b0, divisor_q}) : REMW'(dt);
      dq_q  <= {dq_q[ACCW-2:0], dge};
    end
    if (cmd_i.rate_take) begin
      rate_q <= (span_q > 0) ? dq_q[RATEW-1:0] : '0;
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  assign st    = {srem_q, rad_q[RADW-1 -: 2]};
  assign trial = (SRW + 2)'({root_q, 2'b01});
  assign sge   = (st >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= RADW'(dq_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sge ? SRW'(st - trial) : SRW'(st);
      root_q <= {root_q[SQW-2:0], sge};
      rad_q  <= rad_q << 2;
    end
  end

  assign jitter = (root_q > SQW'(JIT_MAX)) ? JIT_MAX : root_q[JITW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      went_backwards_o     <= bw_q;
      regressions_o        <= bwcnt_q;
      samples_held_o       <= count_q;
      is_stale_o           <= stale_q;
      rate_mhz_o           <= k2_q ? rate_q : '0;
      last_interval_ns_o   <= k2_q ? last_q : '0;
      interval_jitter_ns_o <= k2_q ? jitter : '0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pps_interval_jitter_monitor.sv @@
// pps_interval_jitter_monitor: top level joining sequencer and datapath
// depends on ppsjm_pkg, ppsjm_ctrl, ppsjm_dp
//
// Usage: each request on the in channel is either an observe (operation 0,
// event stamp and receipt time) or a query (operation 1, current time).
// An observe leaves the sequencer idle and gives no result. A query gives one
// result on the out channel with the sticky backwards flag, regression count,
// window fill, staleness, pulse rate in millihertz, newest interval and the
// standard deviation of the intervals.
// Throughput: one request at a time. A query with fewer than two stamps
// skips the walks and goes straight to its result; a query over more stamps
// makes two walks over the single-port stamp memory, with a squaring step of
// low, middle and high partial products per interval, then two 101-step
// restoring divisions and a 51-step square root before its result.
// The result sits in an output register; if the receiver stalls, a finished
// query waits there and the next query holds in its final step until the
// register is free. Configuration writes on the cfg channel are always taken.
// Reset empties the window, clears the flags and counters and restores the
// stale limit to 1.5 s and the window size to 64; no memory clearing is done.
`default_nettype none

module pps_interval_jitter_monitor import ppsjm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic [TW-1:0]        event_stamp_ns_i,
  input  wire logic [TW-1:0]        receipt_time_ns_i,
  input  wire logic [TW-1:0]        now_ns_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      went_backwards_o,
  output logic [BWW-1:0]            regressions_o,
  output logic [CW-1:0]             samples_held_o,
  output logic                      is_stale_o,
  output logic [RATEW-1:0]          rate_mhz_o,
  output logic signed [IVW-1:0]     last_interval_ns_o,
  output logic [JITW-1:0]           interval_jitter_ns_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDXW-1:0]  cfg_index_i,
  input  wire logic [LIMW-1:0]      cfg_data_i
);

  ppsjm_cmd_t cmd;
  ppsjm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ppsjm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppsjm_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_fire_i           (cfg_valid_i & cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .event_stamp_ns_i     (event_stamp_ns_i),
    .receipt_time_ns_i    (receipt_time_ns_i),
    .now_ns_i             (now_ns_i),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .went_backwards_o     (went_backwards_o),
    .regressions_o        (regressions_o),
    .samples_held_o       (samples_held_o),
    .is_stale_o           (is_stale_o),
    .rate_mhz_o           (rate_mhz_o),
    .last_interval_ns_o   (last_interval_ns_o),
    .interval_jitter_ns_o (interval_jitter_ns_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for pps_interval_jitter_monitor
// depends on ppsjm_pkg and the monitor rtl; predicts or is given every query result
`default_nettype none

module testbench;
  import ppsjm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 went_backwards;
    logic [BWW-1:0]       regressions;
    logic [CW-1:0]        samples_held;
    logic                 is_stale;
    logic [RATEW-1:0]     rate_mhz;
    logic signed [IVW-1:0] last_interval_ns;
    logic [JITW-1:0]      interval_jitter_ns;
  } pps_status_t;

  typedef struct {
    bit             is_cfg;
    logic [1:0]     idx;
    logic [31:0]    data;
    logic           op;
    logic [TW-1:0]  a;
    logic [TW-1:0]  b;
    bit             typed;
    pps_status_t    exp;
  } pps_row_t;

  localparam logic [TW-1:0] T_MAX = '1;
  localparam longint IV_HI = 64'sd549755813887;
  localparam longint IV_LO = -64'sd549755813888;
  localparam logic [63:0] RATE_SAT = 64'd70368744177663;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = OP_OBSERVE;
  logic [TW-1:0] event_stamp_ns_i = '0;
  logic [TW-1:0] receipt_time_ns_i = '0;
  logic [TW-1:0] now_ns_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic went_backwards_o;
  logic [BWW-1:0] regressions_o;
  logic [CW-1:0] samples_held_o;
  logic is_stale_o;
  logic [RATEW-1:0] rate_mhz_o;
  logic signed [IVW-1:0] last_interval_ns_o;
  logic [JITW-1:0] interval_jitter_ns_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDXW-1:0] cfg_index_i = CFG_STALE_LIMIT;
  logic [LIMW-1:0] cfg_data_i = '0;

  pps_interval_jitter_monitor uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [TW-1:0] ring [DEPTH];
  int unsigned   ring_head, ring_fill;
  logic [TW-1:0] last_receipt, last_stamp;
  bit            any_seen, back_flag;
  int unsigned   back_count;
  longint        stale_limit;
  int unsigned   win_size;

  pps_status_t pending_status [$];
  bit failed = 1'b0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  pps_row_t rows [$];

  function automatic int unsigned slot(int unsigned i);
    return (ring_head + DEPTH - ring_fill + i) % DEPTH;
  endfunction

  function automatic longint interval_at(int unsigned i);
    longint d;
    d = longint'({1'b0, ring[slot(i)]}) - longint'({1'b0, ring[slot(i - 1)]});
    if (d > IV_HI) d = IV_HI;
    if (d < IV_LO) d = IV_LO;
    return d;
  endfunction

  function automatic void record_pulse(logic [TW-1:0] stamp, logic [TW-1:0] rcpt);
    int unsigned lim;
    lim = win_size > DEPTH ? DEPTH : win_size;
    if (any_seen && stamp < last_stamp) begin
      if (back_count < 65535) back_count++;
      back_flag = 1'b1;
    end
    any_seen = 1'b1;
    last_stamp = stamp;
    last_receipt = rcpt;
    ring[ring_head] = stamp;
    ring_head = (ring_head + 1) % DEPTH;
    if (ring_fill < DEPTH) ring_fill++;
    if (ring_fill > lim) ring_fill = lim;
  endfunction

  function automatic pps_status_t predict_status(logic [TW-1:0] now);
    pps_status_t r;
    int unsigned k, n, i;
    longint age, span, s1, e;
    logic [63:0] m, root, cand, rate, n3;
    logic [127:0] total, c2;
    r = '0;
    k = ring_fill;
    if (k > 0) begin
      age = longint'({1'b0, now}) - longint'({1'b0, last_receipt});
      r.is_stale = (stale_limit < 0) || (age > stale_limit);
    end
    if (k >= 2) begin
      span = longint'({1'b0, ring[slot(k - 1)]}) - longint'({1'b0, ring[slot(0)]});
      if (span > 0) begin
        rate = (64'(k - 1) * 64'd1000000000000) / 64'(span);
        if (rate > RATE_SAT) rate = RATE_SAT;
        r.rate_mhz = rate[RATEW-1:0];
      end
      n = k - 1;
      r.last_interval_ns = IVW'(interval_at(k - 1));
      s1 = 0;
      for (i = 1; i < k; i++) s1 += interval_at(i);
      // deviations scaled by n so the variance stays integer
      total = '0;
      for (i = 1; i < k; i++) begin
        e = longint'(n) * interval_at(i) - s1;
        m = e < 0 ? 64'(-e) : 64'(e);
        total += 128'(m) * 128'(m);
      end
      n3 = 64'(n) * 64'(n) * 64'(n);
      root = '0;
      for (int b = 40; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        c2 = 128'(cand) * 128'(cand) * 128'(n3);
        if (c2 <= total) root = cand;
      end
      r.interval_jitter_ns = root > 64'(JIT_MAX) ? JIT_MAX : root[JITW-1:0];
    end
    r.went_backwards = back_flag;
    r.regressions = back_count[BWW-1:0];
    r.samples_held = ring_fill[CW-1:0];
    return r;
  endfunction

  function automatic logic [TW-1:0] rand63();
    return TW'({$urandom, $urandom});
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_STALE_LIMIT) stale_limit = longint'(signed'(data));
    else if (idx == CFG_WINDOW_SIZE) win_size = data[6:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_request(logic op, logic [TW-1:0] a, logic [TW-1:0] b,
                              bit typed, pps_status_t exp);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    if (op == OP_OBSERVE) begin
      event_stamp_ns_i = a;
      receipt_time_ns_i = b;
      now_ns_i = rand63();
    end else begin
      now_ns_i = a;
      event_stamp_ns_i = rand63();
      receipt_time_ns_i = rand63();
    end
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_OBSERVE) record_pulse(a, b);
    else pending_status.insert(pending_status.size(), typed ? exp : predict_status(a));
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    pps_status_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        $error("result with no query pending");
        failed = 1'b1;
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        if (went_backwards_o !== want.went_backwards) begin
          $error("went_backwards exp %0d got %0d", want.went_backwards, went_backwards_o);
          failed = 1'b1;
        end
        if (regressions_o !== want.regressions) begin
          $error("regressions exp %0d got %0d", want.regressions, regressions_o);
          failed = 1'b1;
        end
        if (samples_held_o !== want.samples_held) begin
          $error("samples_held exp %0d got %0d", want.samples_held, samples_held_o);
          failed = 1'b1;
        end
        if (is_stale_o !== want.is_stale) begin
          $error("is_stale exp %0d got %0d", want.is_stale, is_stale_o);
          failed = 1'b1;
        end
        if (rate_mhz_o !== want.rate_mhz) begin
          $error("rate_mhz exp %0d got %0d", want.rate_mhz, rate_mhz_o);
          failed = 1'b1;
        end
        if (last_interval_ns_o !== want.last_interval_ns) begin
          $error("last_interval_ns exp %0d got %0d", want.last_interval_ns,
                 last_interval_ns_o);
          failed = 1'b1;
        end
        if (interval_jitter_ns_o !== want.interval_jitter_ns) begin
          $error("interval_jitter_ns exp %0d got %0d", want.interval_jitter_ns,
                 interval_jitter_ns_o);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic pps_row_t item_row(logic op, logic [TW-1:0] a, logic [TW-1:0] b);
    pps_row_t r;
    r = '{default: '0};
    r.op = op;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic pps_row_t cfg_row(logic [1:0] idx, logic [31:0] data);
    pps_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic pps_row_t known_row(logic [TW-1:0] now, pps_status_t exp);
    pps_row_t r;
    r = item_row(OP_QUERY, now, '0);
    r.typed = 1'b1;
    r.exp = exp;
    return r;
  endfunction

  initial begin
    pps_status_t one_held;
    logic [TW-1:0] gen_stamp, gen_rcpt, now;
    logic [31:0] limits [6];
    int sizes [6];
    int pick;
    ring_head = 0; ring_fill = 0; last_receipt = '0; last_stamp = '0;
    any_seen = 0; back_flag = 0; back_count = 0;
    stale_limit = 1500000000; win_size = 64;
    one_held = '0;
    one_held.samples_held = 1;

    // directed table
    rows.insert(rows.size(), known_row('0, '0));                     // empty window
    rows.insert(rows.size(), item_row(OP_OBSERVE, 63'd1000, 63'd500));
    rows.insert(rows.size(), known_row(63'd500, one_held));           // single stamp
    rows.insert(rows.size(), item_row(OP_OBSERVE, 63'd1000001000, 63'd1000000000));
    rows.insert(rows.size(), item_row(OP_QUERY, 63'd1000000100, '0));
    rows.insert(rows.size(), item_row(OP_OBSERVE, '0, 63'd2000000000)); // regression
    rows.insert(rows.size(), item_row(OP_OBSERVE, T_MAX, T_MAX));     // interval saturates
    rows.insert(rows.size(), item_row(OP_QUERY, '0, '0));             // receipt after now
    rows.insert(rows.size(), cfg_row(CFG_STALE_LIMIT, 32'hFFFF_FFFF)); // always stale
    rows.insert(rows.size(), item_row(OP_QUERY, T_MAX, '0));
    rows.insert(rows.size(), cfg_row(CFG_STALE_LIMIT, 32'h7FFF_FFFF));
    rows.insert(rows.size(), cfg_row(CFG_WINDOW_SIZE, 32'd2));        // shrink, lazy trim
    rows.insert(rows.size(), item_row(OP_QUERY, T_MAX, '0));
    rows.insert(rows.size(), item_row(OP_OBSERVE, T_MAX, 63'd5));     // span zero
    rows.insert(rows.size(), item_row(OP_QUERY, 63'd5, '0));
    rows.insert(rows.size(), cfg_row(CFG_WINDOW_SIZE, 32'd0));        // empty window
    rows.insert(rows.size(), item_row(OP_OBSERVE, 63'd123, '0));
    rows.insert(rows.size(), item_row(OP_QUERY, '0, '0));
    rows.insert(rows.size(), cfg_row(2'd2, 32'hFFFF_FFFF));           // unused index
    rows.insert(rows.size(), cfg_row(CFG_WINDOW_SIZE, 32'hFFFF_FF7F)); // above depth
    rows.insert(rows.size(), cfg_row(CFG_STALE_LIMIT, 32'h8000_0000));
    rows.insert(rows.size(), item_row(OP_OBSERVE, 63'd500, 63'd7));
    rows.insert(rows.size(), item_row(OP_OBSERVE, 63'd1000000600, 63'd9));
    rows.insert(rows.size(), item_row(OP_QUERY, 63'd9, '0));
    rows.insert(rows.size(), cfg_row(2'd3, 32'h0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_request(rows[i].op, rows[i].a, rows[i].b, rows[i].typed, rows[i].exp);
      end
    end

    limits = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1500000000, $urandom, 32'hFFFF_FFFF};
    sizes = '{8, 1, 64, 3, 127, 2};
    gen_stamp = 63'd5000000000;
    gen_rcpt = 63'd7000000000;
    for (int p = 0; p < 6; p++) begin
      // sender waits here for every pending result before the next setting
      wait_idle();
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_reg(CFG_STALE_LIMIT, limits[p]);
      write_reg(CFG_WINDOW_SIZE, ($urandom & 32'hFFFF_FF80) | 32'(sizes[p]));
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          case ($urandom_range(3))
            0: now = gen_rcpt + TW'($urandom);
            1: now = gen_rcpt - TW'($urandom_range(1000));
            2: now = rand63();
            default: now = gen_rcpt + TW'(stale_limit);
          endcase
          send_request(OP_QUERY, now, '0, 1'b0, '0);
        end else begin
          if (pick < 85) begin
            gen_stamp = gen_stamp + 63'd1000000000 + TW'($urandom_range(2000)) - 63'd1000;
            gen_rcpt = gen_rcpt + 63'd1000000000 + TW'($urandom_range(999999));
          end else if (pick < 92) begin
            gen_stamp = gen_stamp - TW'($urandom);
            gen_rcpt = gen_rcpt + TW'($urandom_range(999999));
          end else begin
            gen_stamp = rand63();
            gen_rcpt = rand63();
          end
          send_request(OP_OBSERVE, gen_stamp, gen_rcpt, 1'b0, '0);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed && pending_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
